// ===== sv/ring_buffer_frame_sync_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer frame sync core
// Shorthand for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_FRAME_SYNC_CORE_MACROS_SVH
`define RING_BUFFER_FRAME_SYNC_CORE_MACROS_SVH

// Same-cycle implication
`define RBFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define RBFS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring buffer frame sync package
// Beat types, opcodes, status codes and register addresses.
// ----------------------------------------------------------------------------
package rbfs_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_DROP  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOFRAME = 2'd2;

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] ADDR_DELIM = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_MAX   = 3'd4;
   localparam logic [11:0] MAX_PAYLOAD_RST = 12'd4080;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        frame_ready;
      logic [12:0] frame_length;
      logic [12:0] fill_level;
   } rsp_type;

   typedef struct packed {
      logic       is_write;
      logic       is_read;
      logic       is_drop;
      logic [7:0] wr_byte;
   } cmd_type;

endpackage

// ===== sv/rbfs_front.sv =====
// ----------------------------------------------------------------------------
// Ring buffer frame sync front end
// Accepts request beats, decodes the opcode and queues up to two commands.
// ----------------------------------------------------------------------------
module rbfs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rbfs_pkg::req_type req_item,
   output logic             cmd_valid,
   output rbfs_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import rbfs_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       take;
   cmd_type    dec;

   // Classify the incoming opcode
   always_comb begin
      dec.is_write = (req_item.opcode == OP_WRITE);
      dec.is_read  = (req_item.opcode == OP_READ);
      dec.is_drop  = (req_item.opcode == OP_DROP);
      dec.wr_byte  = req_item.in_byte;
   end

   assign full      = (cnt_ff == 2'd2);
   assign take      = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = take ? !wr_ff : wr_ff;
      rd_in  = (cmd_pop && cmd_valid) ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(take) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff[wr_ff] <= dec;
      end
   end

endmodule

// ===== sv/rbfs_engine.sv =====
// ----------------------------------------------------------------------------
// Ring buffer frame sync engine
// Executes commands on the byte ring and runs the header sync search.
// ----------------------------------------------------------------------------
module rbfs_engine #(
   parameter int BUF_DEPTH  = 4096,
   parameter int HEADER_LEN = 16,
   parameter int LEN_OFFSET = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  rbfs_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic [31:0]       delim,
   input  logic [11:0]       max_payload,
   output logic              rsp_valid,
   output rbfs_pkg::rsp_type rsp,
   input  logic              rsp_pop
);
   import rbfs_pkg::*;

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = AW + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [1:0] PH_SEARCH  = 2'd0;
   localparam logic [1:0] PH_PENDING = 2'd1;
   localparam logic [1:0] PH_READY   = 2'd2;

   logic [7:0]    mem [BUF_DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [CW-1:0] fill_ff, fill_in, total_ff, total_in, popped_ff, popped_in;
   logic [1:0]    phase_ff, phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    idx_ff, idx_in;
   logic          match_ff, match_in;
   logic [31:0]   plen_ff, plen_in;
   cmd_type       cmd_ff, cmd_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    data_ff, data_in;
   logic          last_ff, last_in, rdok_ff, rdok_in;
   logic [CW-1:0] len_ff, len_in;
   rsp_type       rsp_ff, rsp_in;

   logic [AW-1:0] fetch_off;
   logic [2:0]    sel;
   logic [CW-1:0] rest, pop_next;
   logic          hdr_ok;

   // Header byte offset for the current fetch slot
   always_comb begin
      fetch_off = idx_ff[2] ? (AW'(LEN_OFFSET) + AW'(idx_ff[1:0])) : AW'(idx_ff[1:0]);
      sel       = 3'(idx_ff - 4'd1);
      raddr     = (state_ff == S_FETCH) ? (rptr_ff + fetch_off) : rptr_ff;
      mem_we    = (state_ff == S_EXEC) && cmd_ff.is_write && (fill_ff != CW'(BUF_DEPTH));
      rest      = total_ff - popped_ff;
      if (rest > fill_ff) begin
         rest = fill_ff;
      end
      pop_next  = popped_ff + CW'(1);
      hdr_ok    = match_ff && (plen_ff <= {20'd0, max_payload}) &&
                  ({1'b0, plen_ff} + 33'(HEADER_LEN) <= 33'(BUF_DEPTH));
   end

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Sequence one command and the search that follows it
   always_comb begin
      state_in     = state_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      popped_in    = popped_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      plen_in      = plen_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      rdok_in      = rdok_ff;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            data_in   = 8'd0;
            last_in   = 1'b0;
            rdok_in   = 1'b0;
            len_in    = total_ff;
            if (cmd_ff.is_write) begin
               if (fill_ff == CW'(BUF_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  wptr_in = wptr_ff + AW'(1);
                  fill_in = fill_ff + CW'(1);
               end
            end else if (cmd_ff.is_read || cmd_ff.is_drop) begin
               if (phase_ff != PH_READY) begin
                  status_in = ST_NOFRAME;
               end else if (cmd_ff.is_read) begin
                  data_in   = rdata_ff;
                  rdok_in   = 1'b1;
                  rptr_in   = rptr_ff + AW'(1);
                  fill_in   = fill_ff - CW'(1);
                  popped_in = pop_next;
                  if (pop_next >= total_ff) begin
                     last_in   = 1'b1;
                     popped_in = '0;
                     phase_in  = PH_SEARCH;
                     total_in  = '0;
                  end
               end else begin
                  rptr_in   = rptr_ff + AW'(rest);
                  fill_in   = fill_ff - rest;
                  popped_in = '0;
                  phase_in  = PH_SEARCH;
                  total_in  = '0;
               end
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (phase_ff == PH_SEARCH && fill_ff >= CW'(HEADER_LEN)) begin
               idx_in   = 4'd0;
               match_in = 1'b1;
               plen_in  = 32'd0;
               state_in = S_FETCH;
            end else begin
               if (phase_ff == PH_PENDING && fill_ff >= total_ff) begin
                  phase_in = PH_READY;
               end
               state_in = S_DONE;
            end
         end
         S_FETCH: begin
            // Capture the byte read in the previous cycle
            if (idx_ff != 4'd0) begin
               if (!sel[2]) begin
                  match_in = match_ff && (rdata_ff == delim[{sel[1:0], 3'b000} +: 8]);
               end else begin
                  plen_in[{sel[1:0], 3'b000} +: 8] = rdata_ff;
               end
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd8) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (hdr_ok) begin
               total_in = CW'(HEADER_LEN) + CW'(plen_ff);
               phase_in = PH_PENDING;
            end else begin
               rptr_in = rptr_ff + AW'(1);
               fill_in = fill_ff - CW'(1);
            end
            state_in = S_CHECK;
         end
         S_DONE: begin
            rsp_in.status       = status_ff;
            rsp_in.data_byte    = data_ff;
            rsp_in.last_byte    = last_ff;
            rsp_in.frame_ready  = (phase_ff == PH_READY);
            rsp_in.frame_length = rdok_ff ? 13'(len_ff)
                                  : ((phase_ff == PH_SEARCH) ? 13'd0 : 13'(total_ff));
            rsp_in.fill_level   = 13'(fill_ff);
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         popped_ff    <= '0;
         phase_ff     <= PH_SEARCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         popped_ff    <= popped_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      plen_ff   <= plen_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
      rdok_ff   <= rdok_in;
      len_ff    <= len_in;
      rsp_ff    <= rsp_in;
   end

   // Byte ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wptr_ff] <= cmd_ff.wr_byte;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

// ===== sv/ring_buffer_frame_sync_core.sv =====
// Ring buffer frame sync core: bytes written in are kept in a ring of
// BUF_DEPTH bytes; the head slides until a four-byte delimiter and an
// acceptable little-endian length sit at it, then the frame is flagged ready
// and can be read byte by byte or dropped. One item is handled at a time:
// a write, read or drop passes through the execute, check and done states,
// and each header position examined afterwards adds a check state, the fetch
// state, in which the eight header bytes come one per cycle through the single
// read port of the byte store, and an evaluation state. A resync after a bad
// header advances the head one byte per header position examined. Requests
// queue two deep in front of the engine. The store needs no clearing after
// reset.
// ----------------------------------------------------------------------------
// Ring buffer frame sync core
// Top level: request queue, command engine and register port.
// ----------------------------------------------------------------------------
`include "ring_buffer_frame_sync_core_macros.svh"

module ring_buffer_frame_sync_core #(
   parameter int BUF_DEPTH  = 4096,
   parameter int HEADER_LEN = 16,
   parameter int LEN_OFFSET = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  rbfs_pkg::req_type                req_item,
   output logic                             empty,
   input  logic                             pop,
   output rbfs_pkg::rsp_type                rsp_item,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rbfs_pkg::CSR_AW-1:0]      paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import rbfs_pkg::*;

   logic        cmd_valid, cmd_pop, rsp_valid;
   cmd_type     cmd;
   logic [31:0] delim_ff, delim_in;
   logic [11:0] max_ff, max_in;
   logic        csr_wr;

   rbfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   rbfs_engine #(
      .BUF_DEPTH  (BUF_DEPTH),
      .HEADER_LEN (HEADER_LEN),
      .LEN_OFFSET (LEN_OFFSET)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .delim       (delim_ff),
      .max_payload (max_ff),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_item),
      .rsp_pop     (pop)
   );

   assign empty  = !rsp_valid;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // Decode register writes
   always_comb begin
      delim_in = delim_ff;
      max_in   = max_ff;
      if (csr_wr && paddr == ADDR_DELIM) begin
         delim_in = pwdata;
      end
      if (csr_wr && paddr == ADDR_MAX) begin
         max_in = pwdata[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= 32'd0;
         max_ff   <= MAX_PAYLOAD_RST;
      end else begin
         delim_ff <= delim_in;
         max_ff   <= max_in;
      end
   end

   // Return register contents
   always_comb begin
      unique case (paddr)
         ADDR_DELIM: prdata = delim_ff;
         ADDR_MAX:   prdata = {20'd0, max_ff};
         default:    prdata = 32'd0;
      endcase
   end

   `RBFS_ASSERT_IMP(a_nofr_not_ready, clock, reset, (!empty && rsp_item.status == ST_NOFRAME), (!rsp_item.frame_ready), "no-frame status with frame ready")
   `RBFS_ASSERT_IMP(a_last_is_ok, clock, reset, (!empty && rsp_item.last_byte), (rsp_item.status == ST_OK), "last byte flagged on a failed item")
   `RBFS_ASSERT_IMP(a_data_only_ok, clock, reset, (!empty && rsp_item.data_byte != 8'd0), (rsp_item.status == ST_OK), "data returned on a failed item")

endmodule
